[rtl/arw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window package
// Shared widths, command and verdict codes, and the status struct that the
// window logic hands to the counter bank.
// ----------------------------------------------------------------------------
package arw_pkg;

    localparam int SEQ_W      = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 5;
    localparam int WORD_BITS  = 64;
    localparam int WORD_LOG2  = 6;
    localparam int WINDOW_BITS_DEF = 1024;

    // Window width after reset, in words, before clamping to built storage.
    localparam logic [CFG_W-1:0] RESET_WORDS = 5'd16;

    localparam logic [1:0] CMD_COMMIT = 2'd0;
    localparam logic [1:0] CMD_PEEK   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_REPLAY = 2'd1;
    localparam logic [1:0] VERDICT_STALE  = 2'd2;

    typedef struct packed {
        logic [1:0] verdict;
        logic       bump_accept;
        logic       bump_replay;
        logic       bump_stale;
    } arw_tally_t;

endpackage

[rtl/arw_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay request channel
// Carries one command and sequence number per transfer.
// ----------------------------------------------------------------------------
interface arw_in_if;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [arw_pkg::SEQ_W-1:0]  seq;

    modport source (output valid, output cmd, output seq, input ready);
    modport sink   (input valid, input cmd, input seq, output ready);

endinterface

[rtl/arw_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay result channel
// Carries the verdict and the lifetime counters per transfer.
// ----------------------------------------------------------------------------
interface arw_out_if;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 verdict;
    logic [arw_pkg::CNT_W-1:0]  accepted_count;
    logic [arw_pkg::CNT_W-1:0]  replay_count;
    logic [arw_pkg::CNT_W-1:0]  stale_count;

    modport source (output valid, output verdict, output accepted_count,
                    output replay_count, output stale_count, input ready);
    modport sink   (input valid, input verdict, input accepted_count,
                    input replay_count, input stale_count, output ready);

endinterface

[rtl/arw_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay bitmap and anchor
// Holds the seen bitmap, the highest sequence number and the window width,
// judges each sequence number and updates the window in the same cycle.
// ----------------------------------------------------------------------------
module arw_window #(
    parameter int WINDOW_BITS = arw_pkg::WINDOW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [arw_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        step,
    input  logic [1:0]                  cmd,
    input  logic [arw_pkg::SEQ_W-1:0]   seq,
    output arw_pkg::arw_tally_t         tally
);

    localparam int NWORDS = WINDOW_BITS / arw_pkg::WORD_BITS;
    localparam int IDXW   = $clog2(WINDOW_BITS);
    localparam int WBW    = arw_pkg::CFG_W + arw_pkg::WORD_LOG2;
    localparam logic [arw_pkg::CFG_W-1:0] MAX_WORDS =
        (NWORDS > 31) ? 5'd31 : arw_pkg::CFG_W'(NWORDS);
    localparam logic [arw_pkg::CFG_W-1:0] INIT_WORDS =
        (arw_pkg::RESET_WORDS > MAX_WORDS) ? MAX_WORDS : arw_pkg::RESET_WORDS;
    localparam logic [WINDOW_BITS-1:0] ONE = {{(WINDOW_BITS-1){1'b0}}, 1'b1};

    logic [WINDOW_BITS-1:0]         bitmap_reg, bitmap_next;
    logic [arw_pkg::SEQ_W-1:0]      highest_reg, highest_next;
    logic                           any_seen_reg, any_seen_next;
    logic [arw_pkg::CFG_W-1:0]      words_reg;

    logic [arw_pkg::CFG_W-1:0]      cfg_words;
    logic [WINDOW_BITS-1:0]         cur_mask, cfg_mask;
    logic [WBW-1:0]                 wbits;
    logic                           newer;
    logic [arw_pkg::SEQ_W-1:0]      back_off, fwd_delta;
    logic                           back_stale, fwd_far, seen_bit;
    logic [1:0]                     judged;
    logic [WINDOW_BITS-1:0]         shifted, set_bit;

    // Bits of every word below the given word count are kept, the rest cleared.
    function automatic logic [WINDOW_BITS-1:0] word_mask(
        input logic [arw_pkg::CFG_W-1:0] words
    );
        logic [WINDOW_BITS-1:0] m;
        m = '0;
        for (int w = 0; w < NWORDS; w++)
        begin
            if (w < int'(words))
            begin
                m[w*arw_pkg::WORD_BITS +: arw_pkg::WORD_BITS] = '1;
            end
        end
        return m;
    endfunction

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_words = 5'd1;
        end
        else if (cfg_wdata > MAX_WORDS)
        begin
            cfg_words = MAX_WORDS;
        end
        else
        begin
            cfg_words = cfg_wdata;
        end
    end

    assign cur_mask = word_mask(words_reg);
    assign cfg_mask = word_mask(cfg_words);
    assign wbits    = {words_reg, {arw_pkg::WORD_LOG2{1'b0}}};

    assign newer      = seq > highest_reg;
    assign back_off   = highest_reg - seq;
    assign fwd_delta  = seq - highest_reg;
    assign back_stale = back_off >= arw_pkg::SEQ_W'(wbits);
    assign fwd_far    = fwd_delta >= arw_pkg::SEQ_W'(wbits);

    // Offsets inside the window fit the index width, so the low bits suffice.
    assign seen_bit = bitmap_reg[back_off[IDXW-1:0]];
    assign shifted  = (bitmap_reg << fwd_delta[IDXW-1:0]) & cur_mask;
    assign set_bit  = ONE << back_off[IDXW-1:0];

    always_comb
    begin
        if (!any_seen_reg || newer)
        begin
            judged = arw_pkg::VERDICT_ACCEPT;
        end
        else if (back_stale)
        begin
            judged = arw_pkg::VERDICT_STALE;
        end
        else if (seen_bit)
        begin
            judged = arw_pkg::VERDICT_REPLAY;
        end
        else
        begin
            judged = arw_pkg::VERDICT_ACCEPT;
        end
    end

    always_comb
    begin
        bitmap_next       = bitmap_reg;
        highest_next      = highest_reg;
        any_seen_next     = any_seen_reg;
        tally.verdict     = arw_pkg::VERDICT_ACCEPT;
        tally.bump_accept = 1'b0;
        tally.bump_replay = 1'b0;
        tally.bump_stale  = 1'b0;
        case (cmd)
            arw_pkg::CMD_COMMIT:
            begin
                if (!any_seen_reg)
                begin
                    any_seen_next     = 1'b1;
                    highest_next      = seq;
                    bitmap_next       = bitmap_reg | ONE;
                    tally.bump_accept = 1'b1;
                end
                else if (newer)
                begin
                    highest_next      = seq;
                    bitmap_next       = (fwd_far ? '0 : shifted) | ONE;
                    tally.bump_accept = 1'b1;
                end
                else
                begin
                    tally.verdict = judged;
                    if (judged == arw_pkg::VERDICT_STALE)
                    begin
                        tally.bump_stale = 1'b1;
                    end
                    else if (judged == arw_pkg::VERDICT_REPLAY)
                    begin
                        tally.bump_replay = 1'b1;
                    end
                    else
                    begin
                        bitmap_next       = bitmap_reg | set_bit;
                        tally.bump_accept = 1'b1;
                    end
                end
            end
            arw_pkg::CMD_PEEK:
            begin
                tally.verdict = judged;
            end
            arw_pkg::CMD_CLEAR:
            begin
                bitmap_next   = '0;
                highest_next  = '0;
                any_seen_next = 1'b0;
            end
            default:
            begin
                tally.verdict = arw_pkg::VERDICT_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg   <= '0;
            highest_reg  <= '0;
            any_seen_reg <= 1'b0;
            words_reg    <= INIT_WORDS;
        end
        else if (cfg_we)
        begin
            // Narrowing the window drops the words beyond the new width.
            words_reg  <= cfg_words;
            bitmap_reg <= bitmap_reg & cfg_mask;
        end
        else if (step)
        begin
            bitmap_reg   <= bitmap_next;
            highest_reg  <= highest_next;
            any_seen_reg <= any_seen_next;
        end
    end

endmodule

[rtl/arw_counters.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay lifetime counters
// Three saturating counters of accepted, replayed and stale packets.
// ----------------------------------------------------------------------------
module arw_counters (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  arw_pkg::arw_tally_t         tally,
    output logic [arw_pkg::CNT_W-1:0]   accepted_count,
    output logic [arw_pkg::CNT_W-1:0]   replay_count,
    output logic [arw_pkg::CNT_W-1:0]   stale_count
);

    logic [arw_pkg::CNT_W-1:0] acc_reg, acc_next;
    logic [arw_pkg::CNT_W-1:0] rep_reg, rep_next;
    logic [arw_pkg::CNT_W-1:0] stl_reg, stl_next;

    // Each counter holds at its maximum instead of wrapping.
    always_comb
    begin
        acc_next = acc_reg;
        rep_next = rep_reg;
        stl_next = stl_reg;
        if (tally.bump_accept && acc_reg != '1)
        begin
            acc_next = acc_reg + 1'b1;
        end
        if (tally.bump_replay && rep_reg != '1)
        begin
            rep_next = rep_reg + 1'b1;
        end
        if (tally.bump_stale && stl_reg != '1)
        begin
            stl_next = stl_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rep_reg <= '0;
            stl_reg <= '0;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
            rep_reg <= rep_next;
            stl_reg <= stl_next;
        end
    end

    assign accepted_count = acc_reg;
    assign replay_count   = rep_reg;
    assign stale_count    = stl_reg;

endmodule

[rtl/anti_replay_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window, top level
// Sliding-window replay check of packet sequence numbers with lifetime
// counters, one packet judged per clock while results are being taken.
// ----------------------------------------------------------------------------
// The block judges one sequence number per clock cycle, back to back: a request
// transfer is taken in every cycle in which the result register is empty or
// its current result is being taken, and its result is presented in the cycle
// after the transfer. The whole update of the window is combinational: the
// comparison against the highest number seen, the shift of the whole bitmap
// for a newer number and the set of one bit all finish between the request
// transfer and the result register. The bitmap is WINDOW_BITS flip-flops
// that reset clears at once, so no clearing pass follows reset. A commit
// (command 0) accepts the first packet and any newer number, reports a
// number a full window width or more behind the highest as stale, a number
// already seen as a replay, and otherwise marks it and accepts it. A peek
// (command 1) reports the same verdict and changes nothing; a clear
// (command 2) empties the window and keeps the counters. Each result carries
// the three saturating lifetime counters after that packet. The width register
// is given in 64-bit words, clamped to 1 up to the built storage, and is only
// to be written while no result is outstanding.
// ----------------------------------------------------------------------------
module anti_replay_window #(
    parameter int WINDOW_BITS = arw_pkg::WINDOW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [arw_pkg::CFG_W-1:0]   cfg_wdata,
    arw_in_if.sink                      req,
    arw_out_if.source                   rsp
);

    logic                   accept;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [1:0]             verdict_reg;
    arw_pkg::arw_tally_t    tally;

    // A new request is taken whenever the result register is free this cycle,
    // either empty or being drained by the consumer.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Window state: bitmap, anchor and width register.
    arw_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (accept),
        .cmd       (req.cmd),
        .seq       (req.seq),
        .tally     (tally)
    );

    // The counters update on the same edge that loads the result register, and
    // they cannot change again until that result has been taken, so they serve
    // directly as the count fields of the result.
    arw_counters u_counters (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .tally          (tally),
        .accepted_count (rsp.accepted_count),
        .replay_count   (rsp.replay_count),
        .stale_count    (rsp.stale_count)
    );

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            verdict_reg <= tally.verdict;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.verdict = verdict_reg;

`ifndef NO_ASSERTIONS
    // Peek, clear and the unused command never move the lifetime counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd != arw_pkg::CMD_COMMIT |=>
            $stable(rsp.accepted_count) && $stable(rsp.replay_count)
            && $stable(rsp.stale_count))
    else $error("counters changed on a non-commit command");

    // A commit lands in exactly one of the three tallies.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd == arw_pkg::CMD_COMMIT |->
            $countones({tally.bump_accept, tally.bump_replay, tally.bump_stale}) == 1)
    else $error("commit did not select exactly one tally");

    // A stale commit below saturation shows up as one more stale packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && tally.bump_stale && rsp.stale_count != '1 |=>
            rsp.stale_count == $past(rsp.stale_count) + 1'b1)
    else $error("stale counter did not advance");

    // Every request transfer produces a result in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
    else $error("result missing after request transfer");
`endif

endmodule
